>>> rtl/fgac_pkg.sv
// shared types and constants for the finite group axiom checker
package fgac_pkg;

	localparam int ELEM_W    = 4;
	localparam int ORDER_W   = 5;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_PAD_W  = OUT_DATA_W - 9;

	localparam logic [ORDER_W-1:0] ORDER_RST = 5'd16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CM1,
		S_CM2,
		S_ID,
		S_DRN,
		S_INV,
		S_AV,
		S_AU,
		S_AW,
		S_AZ,
		S_FIN,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		T_NONE,
		T_C1,
		T_C2,
		T_ID,
		T_INV,
		T_V,
		T_U,
		T_W,
		T_Z
	} tag_t;

	typedef struct packed {
		logic              has_identity;
		logic [ELEM_W-1:0] identity_index;
		logic              commutative;
		logic              has_inverses;
		logic              associative;
		logic              is_group;
	} res_t;

endpackage

>>> rtl/finite_group_axiom_check.sv
// top level: operation table loader and group axiom checker
// loading: one word per cycle while idle, not during a check nor until its result is taken
// check on a word with tlast, over the n elements in use; the table memory has a
//   single read port, so the check makes at most one table read per cycle
// the result waits in an output register; loading resumes while it waits
// reset clears control state and sets order to 16; table contents stay undefined until written
module finite_group_axiom_check import fgac_pkg::*; #(
	parameter int MAX_ORDER = 16,
	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
	localparam int VW = (IDX_W > ELEM_W) ? IDX_W : ELEM_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // row, col, product, zero pad
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // has_identity, identity_index, commutative,
	                                         // has_inverses, associative, is_group, zero pad
	input  logic                  cfg_wen,
	input  logic [ORDER_W-1:0]    cfg_wdata
);

	logic [ORDER_W-1:0]    order_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  in_acc;
	logic                  idle;
	logic                  rd_en;
	logic [VW-1:0]         rd_row, rd_col;
	logic [ELEM_W-1:0]     rd_data;
	res_t                  res;
	logic                  res_valid;
	logic                  res_ready;

	assign s_tready  = idle;
	assign in_acc    = s_tvalid && idle;
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RST;
		end else if (cfg_wen) begin
			order_q <= cfg_wdata;
		end
	end

	fgac_table #(.MAX_ORDER(MAX_ORDER)) u_table (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_row  (s_tdata[3:0]),
		.wr_col  (s_tdata[7:4]),
		.wr_data (s_tdata[11:8]),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_col  (rd_col),
		.rd_data (rd_data)
	);

	fgac_seq #(.MAX_ORDER(MAX_ORDER)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc && s_tlast),
		.order     (order_q),
		.idle      (idle),
		.rd_en     (rd_en),
		.rd_row    (rd_row),
		.rd_col    (rd_col),
		.rd_data   (rd_data),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, res.is_group, res.associative, res.has_inverses,
				res.commutative, res.identity_index, res.has_identity};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/fgac_table.sv
// operation table memory, one write port and one registered read port
module fgac_table import fgac_pkg::*; #(
	parameter int MAX_ORDER = 16,
	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
	localparam int VW = (IDX_W > ELEM_W) ? IDX_W : ELEM_W
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ELEM_W-1:0] wr_row,
	input  logic [ELEM_W-1:0] wr_col,
	input  logic [ELEM_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [VW-1:0]     rd_row,
	input  logic [VW-1:0]     rd_col,
	output logic [ELEM_W-1:0] rd_data
);

	localparam int DEPTH = 1 << (2 * IDX_W);

	logic [ELEM_W-1:0]  mem [DEPTH];
	logic [ELEM_W-1:0]  rd_q;
	logic               oob_s1;
	logic               we;
	logic               rd_oob;
	logic [2*IDX_W-1:0] waddr;
	logic [2*IDX_W-1:0] raddr;

	assign we     = wr_en && (32'(wr_row) < MAX_ORDER) && (32'(wr_col) < MAX_ORDER);
	assign waddr  = {IDX_W'(wr_row), IDX_W'(wr_col)};
	assign raddr  = {rd_row[IDX_W-1:0], rd_col[IDX_W-1:0]};
	assign rd_oob = (32'(rd_row) >= MAX_ORDER) || (32'(rd_col) >= MAX_ORDER);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wr_data;
		end
		if (rd_en) begin
			rd_q   <= mem[raddr];
			oob_s1 <= rd_oob;
		end
	end

	// operands beyond the table read as zero
	assign rd_data = oob_s1 ? '0 : rd_q;

endmodule

>>> rtl/fgac_seq.sv
// check sequencer: walks the table and evaluates the axioms
module fgac_seq import fgac_pkg::*; #(
	parameter int MAX_ORDER = 16,
	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
	localparam int VW = (IDX_W > ELEM_W) ? IDX_W : ELEM_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ORDER_W-1:0] order,
	output logic               idle,
	output logic               rd_en,
	output logic [VW-1:0]      rd_row,
	output logic [VW-1:0]      rd_col,
	input  logic [ELEM_W-1:0]  rd_data,
	output res_t               res,
	output logic               res_valid,
	input  logic               res_ready
);

	state_t state_q, state_d;
	tag_t   tag_d, tag_s1;

	logic [IDX_W-1:0]  nm1_q, a_q, x_q, y_q, e_q;
	logic [IDX_W-1:0]  nm1_d;
	logic [IDX_W-1:0]  ctx_x_s1, ctx_a_s1;
	logic              ctx_last_s1;
	logic [ELEM_W-1:0] t_q, v_q, w_q;
	logic              comm_q, ident_q, ok_q, inv_q, fnd_q, assoc_q;
	logic              a_last, x_last, y_last, xa_last;
	logic              skip_x, skip_y;
	logic              id_ok, inv_hit;

	assign a_last  = (a_q == nm1_q);
	assign x_last  = (x_q == nm1_q);
	assign y_last  = (y_q == nm1_q);
	assign xa_last = x_last && a_last;
	assign skip_x  = ident_q && (x_q == e_q);
	assign skip_y  = ident_q && (y_q == e_q);
	assign id_ok   = ok_q && (VW'(rd_data) == VW'(ctx_x_s1));
	assign inv_hit = fnd_q || (VW'(rd_data) == VW'(e_q));

	// clamp order to 1..MAX_ORDER, kept as order minus one
	always_comb begin
		if (order == '0) begin
			nm1_d = '0;
		end else if (32'(order) > MAX_ORDER) begin
			nm1_d = IDX_W'(MAX_ORDER - 1);
		end else begin
			nm1_d = IDX_W'(order - ORDER_W'(1));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_CM1;
			S_CM1:  state_d = S_CM2;
			S_CM2:  state_d = xa_last ? S_ID : S_CM1;
			S_ID:   if (xa_last) state_d = S_DRN;
			S_DRN:  state_d = S_INV;
			S_INV:  if (xa_last) state_d = S_AV;
			S_AV: begin
				if (skip_x) begin
					state_d = xa_last ? S_FIN : S_AV;
				end else begin
					state_d = S_AU;
				end
			end
			S_AU: begin
				if (!skip_y) begin
					state_d = S_AW;
				end else if (y_last) begin
					state_d = xa_last ? S_FIN : S_AV;
				end
			end
			S_AW:   state_d = S_AZ;
			S_AZ: begin
				if (y_last) begin
					state_d = xa_last ? S_FIN : S_AV;
				end else begin
					state_d = S_AU;
				end
			end
			S_FIN:  state_d = S_DONE;
			S_DONE: if (res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// read requests
	always_comb begin
		rd_en  = 1'b0;
		rd_row = '0;
		rd_col = '0;
		tag_d  = T_NONE;
		unique case (state_q)
			S_CM1: begin
				rd_en = 1'b1; rd_row = VW'(a_q); rd_col = VW'(x_q); tag_d = T_C1;
			end
			S_CM2: begin
				rd_en = 1'b1; rd_row = VW'(x_q); rd_col = VW'(a_q); tag_d = T_C2;
			end
			S_ID: begin
				rd_en = 1'b1; rd_row = VW'(x_q); rd_col = VW'(a_q); tag_d = T_ID;
			end
			S_INV: begin
				rd_en = 1'b1; rd_row = VW'(a_q); rd_col = VW'(x_q); tag_d = T_INV;
			end
			S_AV: begin
				if (!skip_x) begin
					rd_en = 1'b1; rd_row = VW'(x_q); rd_col = VW'(a_q); tag_d = T_V;
				end
			end
			S_AU: begin
				if (!skip_y) begin
					rd_en = 1'b1; rd_row = VW'(a_q); rd_col = VW'(y_q); tag_d = T_U;
				end
			end
			S_AW: begin
				rd_en = 1'b1; rd_row = VW'(x_q); rd_col = VW'(rd_data); tag_d = T_W;
			end
			S_AZ: begin
				rd_en = 1'b1; rd_row = VW'(v_q); rd_col = VW'(y_q); tag_d = T_Z;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tag_s1      <= T_NONE;
			ctx_last_s1 <= 1'b0;
			nm1_q       <= '0;
			a_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			e_q         <= '0;
			comm_q      <= 1'b1;
			ident_q     <= 1'b0;
			ok_q        <= 1'b1;
			inv_q       <= 1'b1;
			fnd_q       <= 1'b0;
			assoc_q     <= 1'b1;
		end else begin
			state_q     <= state_d;
			tag_s1      <= tag_d;
			ctx_last_s1 <= x_last;

			// evaluate returning words
			unique case (tag_s1)
				T_C2: if (rd_data != t_q) comm_q <= 1'b0;
				T_ID: begin
					if (ctx_last_s1) begin
						if (id_ok && !ident_q) begin
							ident_q <= 1'b1;
							e_q     <= ctx_a_s1;
						end
						ok_q <= 1'b1;
					end else begin
						ok_q <= id_ok;
					end
				end
				T_INV: begin
					if (ctx_last_s1) begin
						if (!inv_hit) inv_q <= 1'b0;
						fnd_q <= 1'b0;
					end else begin
						fnd_q <= inv_hit;
					end
				end
				T_Z: if (rd_data != w_q) assoc_q <= 1'b0;
				default: ;
			endcase

			// loop counters; start also loads the order and resets the result flags
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						nm1_q   <= nm1_d;
						a_q     <= '0;
						x_q     <= '0;
						y_q     <= '0;
						e_q     <= '0;
						comm_q  <= 1'b1;
						ident_q <= 1'b0;
						ok_q    <= 1'b1;
						inv_q   <= 1'b1;
						fnd_q   <= 1'b0;
						assoc_q <= 1'b1;
					end
				end
				S_CM2, S_ID, S_INV: begin
					if (x_last) begin
						x_q <= '0;
						a_q <= a_last ? '0 : a_q + IDX_W'(1);
					end else begin
						x_q <= x_q + IDX_W'(1);
					end
				end
				S_AV: begin
					y_q <= '0;
					if (skip_x) begin
						if (x_last) begin
							x_q <= '0;
							a_q <= a_last ? '0 : a_q + IDX_W'(1);
						end else begin
							x_q <= x_q + IDX_W'(1);
						end
					end
				end
				S_AU, S_AZ: begin
					if ((state_q == S_AZ) || skip_y) begin
						if (y_last) begin
							y_q <= '0;
							if (x_last) begin
								x_q <= '0;
								a_q <= a_last ? '0 : a_q + IDX_W'(1);
							end else begin
								x_q <= x_q + IDX_W'(1);
							end
						end else begin
							y_q <= y_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// operand holding registers
	always_ff @(posedge clk) begin
		ctx_x_s1 <= x_q;
		ctx_a_s1 <= a_q;
		if (tag_s1 == T_C1) t_q <= rd_data;
		if (tag_s1 == T_V)  v_q <= rd_data;
		if (tag_s1 == T_W)  w_q <= rd_data;
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.has_identity   = ident_q;
		res.identity_index = ident_q ? ELEM_W'(e_q) : '0;
		res.commutative    = comm_q;
		res.has_inverses   = ident_q && inv_q;
		res.associative    = assoc_q;
		res.is_group       = ident_q && inv_q && assoc_q;
	end

endmodule
